// ----- hw/rtl/sm3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sm3_pkg;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_OUT
	} sm3_state_t;

	localparam int unsigned WORDS_PER_MSG = 12;
	localparam int unsigned ROUNDS        = 64;
	localparam int unsigned DIGEST_WORDS  = 8;

	localparam logic [31:0] T_LOW   = 32'h79cc4519;
	localparam logic [31:0] T_HIGH  = 32'h7a879d8a;
	localparam logic [31:0] PAD_ONE = 32'h80000000;
	localparam logic [31:0] PAD_LEN = 32'h00000180;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [5:0] rn;
		rn = 6'd32 - {1'b0, n};
		return (x << n) | (x >> rn);
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = 32'h7380166f;
			3'd1: v = 32'h4914b2b9;
			3'd2: v = 32'h172442d7;
			3'd3: v = 32'hda8a0600;
			3'd4: v = 32'ha96f30bc;
			3'd5: v = 32'h163138aa;
			3'd6: v = 32'he38dee4d;
			3'd7: v = 32'hb0fb0e4e;
			default: v = 32'h7380166f;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sm3_single_block_hash_unit.sv -----
// Twelve message items are taken one per cycle while message_valid is high, then 64
// compression rounds run at one round per cycle, then eight digest items leave one
// per cycle while digest_ready is high. A single round datapath is reused for every
// round, and no new message is taken until the last digest item has left.
// Reset: arst_n clears the sequencer, word count and round count; the block
// then waits for the first message item.
`timescale 1ns / 1ps
`default_nettype none

module sm3_single_block_hash_unit
	import sm3_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] message_word,
	input  wire logic        message_valid,
	output logic             message_ready,
	output logic [31:0]      digest_word,
	output logic             last_word,
	output logic             digest_valid,
	input  wire logic        digest_ready
);

	sm3_state_t state_q, state_d;

	logic [3:0]  words_q;
	logic [5:0]  round_q;
	logic [2:0]  out_cnt_q;
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

	logic        in_acc, out_acc, last_in;
	logic        low_round;
	logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, next_w;

	assign in_acc  = message_valid && message_ready;
	assign out_acc = digest_valid && digest_ready;
	assign last_in = (words_q == 4'(WORDS_PER_MSG - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && last_in) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == 6'(ROUNDS - 1)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_acc && out_cnt_q == 3'(DIGEST_WORDS - 1)) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		message_ready = 1'b0;
		digest_valid  = 1'b0;
		last_word     = 1'b0;
		case (state_q)
			ST_LOAD: begin
				message_ready = 1'b1;
			end
			ST_ROUND: begin
				message_ready = 1'b0;
			end
			ST_OUT: begin
				digest_valid = 1'b1;
				last_word    = (out_cnt_q == 3'(DIGEST_WORDS - 1));
			end
			default: begin
				message_ready = 1'b0;
			end
		endcase
	end

	assign digest_word = a_q ^ iv_word(out_cnt_q);

	always_comb begin
		low_round = (round_q < 6'd16);
		tj  = low_round ? T_LOW : T_HIGH;
		a12 = rotl(a_q, 5'd12);
		ss1 = rotl(a12 + e_q + rotl(tj, round_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		ff  = low_round ? (a_q ^ b_q ^ c_q) : ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
		gg  = low_round ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
		tt1 = ff + d_q + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + h_q + ss1 + w_q[0];
		next_w = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
			^ rotl(w_q[3], 5'd7) ^ w_q[10];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			words_q   <= '0;
			round_q   <= '0;
			out_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				words_q <= last_in ? 4'd0 : words_q + 4'd1;
			end
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (out_acc) begin
				out_cnt_q <= out_cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (last_in) begin
				for (int i = 0; i < 11; i++) w_q[i] <= w_q[i + 5];
				w_q[11] <= message_word;
				w_q[12] <= PAD_ONE;
				w_q[13] <= '0;
				w_q[14] <= '0;
				w_q[15] <= PAD_LEN;
				a_q <= iv_word(3'd0);
				b_q <= iv_word(3'd1);
				c_q <= iv_word(3'd2);
				d_q <= iv_word(3'd3);
				e_q <= iv_word(3'd4);
				f_q <= iv_word(3'd5);
				g_q <= iv_word(3'd6);
				h_q <= iv_word(3'd7);
			end else begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= message_word;
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= next_w;
			a_q <= tt1;
			b_q <= a_q;
			c_q <= rotl(b_q, 5'd9);
			d_q <= c_q;
			e_q <= perm0(tt2);
			f_q <= e_q;
			g_q <= rotl(f_q, 5'd19);
			h_q <= g_q;
		end else if (out_acc) begin
			// rotate so the next digest word sits in a_q
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
			e_q <= f_q;
			f_q <= g_q;
			g_q <= h_q;
			h_q <= a_q;
		end
	end

	a_start_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_in) |=> (state_q == ST_ROUND && round_q == 6'd0))
		else $error("compression did not start at round zero");

	a_end_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == 6'(ROUNDS - 1)) |=>
		(digest_valid && out_cnt_q == 3'd0))
		else $error("digest not presented after the last round");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(message_ready && digest_valid))
		else $error("input taken while digest pending");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (message_ready && words_q == 4'd0))
		else $error("block not ready for next message after last digest item");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import sm3_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_item_t;

	localparam int RANDOM_MESSAGES  = 37;
	localparam int DRAIN_AT         = 20;
	localparam int LONG_HOLD_AT     = 12;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int QUIET_AFTER      = 31;
	localparam int STALL_LIMIT      = 3000;
	localparam int TAIL_CYCLES      = 120;

	localparam logic [0:7][31:0] SM3_IV = {
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	localparam logic [0:23][31:0] DIRECTED_WORDS = {
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'hffffffff, 32'h00000001, 32'h80000000, 32'h7fffffff,
		32'hfffffffe, 32'h55555555, 32'haaaaaaaa, 32'h0000ffff,
		32'hffff0000, 32'h80000000, 32'h00000180, 32'hffffffff
	};

	logic        clk;
	logic        arst_n;
	logic [31:0] message_word;
	logic        message_valid;
	logic        message_ready;
	logic [31:0] digest_word;
	logic        last_word;
	logic        digest_valid;
	logic        digest_ready;

	logic [31:0]  message_buf [0:11];
	digest_item_t expected_digest_q [$];
	int           word_count;
	int           messages_hashed;
	int           mismatch_count;
	int           stall_cycles;
	logic         quiet_tail;

	assign quiet_tail = (messages_hashed >= QUIET_AFTER);

	sm3_single_block_hash_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.message_word (message_word),
		.message_valid(message_valid),
		.message_ready(message_ready),
		.digest_word  (digest_word),
		.last_word    (last_word),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
		int unsigned s;
		s = n % 32;
		if (s == 0)
			return x;
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic logic [31:0] mix_p0(input logic [31:0] x);
		return x ^ rol32(x, 9) ^ rol32(x, 17);
	endfunction

	function automatic logic [31:0] mix_p1(input logic [31:0] x);
		return x ^ rol32(x, 15) ^ rol32(x, 23);
	endfunction

	function automatic void predict_digest();
		logic [31:0]  sched [0:15];
		logic [31:0]  a, b, c, d, e, f, g, h;
		logic [31:0]  wj, wp, tj, a12, ss1, ss2, ff, gg, tt1, tt2, nxt;
		logic [0:7][31:0] fin;
		digest_item_t item;
		int           j;
		for (j = 0; j < WORDS_PER_MSG; j++)
			sched[j] = message_buf[j];
		sched[12] = PAD_ONE;
		sched[13] = 32'h0;
		sched[14] = 32'h0;
		sched[15] = PAD_LEN;
		a = SM3_IV[0]; b = SM3_IV[1]; c = SM3_IV[2]; d = SM3_IV[3];
		e = SM3_IV[4]; f = SM3_IV[5]; g = SM3_IV[6]; h = SM3_IV[7];
		for (j = 0; j < ROUNDS; j++) begin
			wj  = sched[j % 16];
			wp  = wj ^ sched[(j + 4) % 16];
			tj  = (j < 16) ? T_LOW : T_HIGH;
			a12 = rol32(a, 12);
			ss1 = rol32(a12 + e + rol32(tj, j), 7);
			ss2 = ss1 ^ a12;
			ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
			gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
			tt1 = ff + d + ss2 + wp;
			tt2 = gg + h + ss1 + wj;
			d = c;
			c = rol32(b, 9);
			b = a;
			a = tt1;
			h = g;
			g = rol32(f, 19);
			f = e;
			e = mix_p0(tt2);
			nxt = mix_p1(wj ^ sched[(j + 7) % 16] ^ rol32(sched[(j + 13) % 16], 15))
				^ rol32(sched[(j + 3) % 16], 7) ^ sched[(j + 10) % 16];
			sched[j % 16] = nxt;
		end
		fin = {a, b, c, d, e, f, g, h};
		for (j = 0; j < DIGEST_WORDS; j++) begin
			item.word = fin[j] ^ SM3_IV[j];
			item.last = (j == DIGEST_WORDS - 1);
			expected_digest_q.push_back(item);
		end
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] bit_mask;
		bit_mask = 32'h1 << $urandom_range(0, 31);
		case ($urandom_range(0, 9))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			2: return bit_mask;
			3: return ~bit_mask;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		digest_item_t exp_item;
		if (arst_n) begin
			if ((message_valid && message_ready) || (digest_valid && digest_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
			if (message_valid && message_ready) begin
				message_buf[word_count] = message_word;
				word_count++;
				if (word_count == WORDS_PER_MSG) begin
					predict_digest();
					word_count = 0;
					messages_hashed++;
				end
			end
			if (digest_valid && digest_ready) begin
				if (expected_digest_q.size() == 0) begin
					$error("unexpected digest item %h (last %b)", digest_word, last_word);
					mismatch_count++;
				end else begin
					exp_item = expected_digest_q.pop_front();
					if (digest_word !== exp_item.word) begin
						$error("digest_word: expected %h, actual %h",
							exp_item.word, digest_word);
						mismatch_count++;
					end
					if (last_word !== exp_item.last) begin
						$error("last_word: expected %b, actual %b",
							exp_item.last, last_word);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		int  stall_left;
		logic long_hold_done;
		stall_left     = 0;
		long_hold_done = 1'b0;
		digest_ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n) begin
				if (!long_hold_done && messages_hashed == LONG_HOLD_AT) begin
					long_hold_done = 1'b1;
					stall_left     = LONG_HOLD_CYCLES;
				end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 17);
				end
				if (stall_left > 0) begin
					digest_ready <= 1'b0;
					stall_left--;
				end else begin
					digest_ready <= 1'b1;
				end
			end
		end
	end

	task automatic offer_word(input logic [31:0] w);
		message_word  <= w;
		message_valid <= 1'b1;
		do
			@(posedge clk);
		while (!message_ready);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			message_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	initial begin
		int k;
		int msg_idx;
		arst_n          = 1'b0;
		message_word    = 32'h0;
		message_valid   = 1'b0;
		word_count      = 0;
		messages_hashed = 0;
		mismatch_count  = 0;
		stall_cycles    = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < 24; k++) begin
			offer_word(DIRECTED_WORDS[k]);
			sender_gap();
		end

		for (msg_idx = 0; msg_idx < RANDOM_MESSAGES; msg_idx++) begin
			if (msg_idx == DRAIN_AT) begin
				message_valid <= 1'b0;
				@(negedge clk);
				while (expected_digest_q.size() != 0)
					@(negedge clk);
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			for (k = 0; k < WORDS_PER_MSG; k++) begin
				offer_word(pick_word());
				sender_gap();
			end
		end

		message_valid <= 1'b0;
		@(negedge clk);
		while (expected_digest_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_digest_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_single_block_hash_unit.sv
tb/sv/tb.sv
